FILE: rtl/rcr_pkg.sv
`timescale 1ns / 1ps

package rcr_pkg;

    // Value and intermediate widths
    localparam int VALUE_W = 32;
    localparam int MAG_W   = VALUE_W + 1;
    localparam int E_W     = 17;
    localparam int GAIN_W  = 18;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int NUM_W   = PROD_W + VALUE_W;
    localparam int DEN_W   = VALUE_W + 1;
    localparam int SPLIT_W = (PROD_W + 1) / 2;
    localparam int HI_W    = PROD_W - SPLIT_W;
    localparam int QSH     = 16;
    localparam int RES_W   = PROD_W - QSH + 2;

    localparam logic [E_W-1:0] RESTITUTION_ONE = E_W'(65536);

    typedef struct packed {
        logic signed [VALUE_W-1:0] first_vel_x;
        logic signed [VALUE_W-1:0] first_vel_y;
        logic signed [VALUE_W-1:0] first_vel_z;
        logic signed [VALUE_W-1:0] second_vel_x;
        logic signed [VALUE_W-1:0] second_vel_y;
        logic signed [VALUE_W-1:0] second_vel_z;
        logic        [VALUE_W-1:0] first_mass;
        logic        [VALUE_W-1:0] second_mass;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_first_vel_x;
        logic signed [VALUE_W-1:0] new_first_vel_y;
        logic signed [VALUE_W-1:0] new_first_vel_z;
        logic signed [VALUE_W-1:0] new_second_vel_x;
        logic signed [VALUE_W-1:0] new_second_vel_y;
        logic signed [VALUE_W-1:0] new_second_vel_z;
        logic                      zero_mass_error;
        logic                      saturated;
    } rsp_t;

    // Per-item data that rides alongside the dividers
    typedef struct packed {
        logic [2:0][VALUE_W-1:0] v1;
        logic [2:0][VALUE_W-1:0] v2;
        logic [2:0]              neg;
        logic                    err;
    } side_t;

    typedef logic [2:0][NUM_W-1:0]  num_vec_t;
    typedef logic [2:0][PROD_W-1:0] quot_vec_t;

    // Clamp to the signed value range; MSB of the result is the clip flag
    function automatic logic [VALUE_W:0] clamp_val(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        logic [VALUE_W:0]        r;
        hi = RES_W'({1'b0, {(VALUE_W-1){1'b1}}});
        lo = -hi - RES_W'(1);
        if (v > hi)
        begin
            r = {1'b1, hi[VALUE_W-1:0]};
        end
        else if (v < lo)
        begin
            r = {1'b1, lo[VALUE_W-1:0]};
        end
        else
        begin
            r = {1'b0, v[VALUE_W-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/rcr_front.sv
`timescale 1ns / 1ps

module rcr_front
    import rcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  req_t              req,
    input  logic [GAIN_W-1:0] gain,
    output logic              out_valid,
    output num_vec_t          num_a,
    output num_vec_t          num_b,
    output logic [DEN_W-1:0]  den,
    output side_t             side
);

    logic [3:0] vld_reg;

    // Stage 1 registers
    logic [2:0][MAG_W-1:0]   mag1_reg;
    logic [VALUE_W-1:0]      m1_1_reg, m2_1_reg;
    logic [DEN_W-1:0]        den1_reg;
    logic [GAIN_W-1:0]       gain1_reg;
    side_t                   side1_reg;
    // Stage 2 registers
    logic [2:0][PROD_W-1:0]  a2_reg;
    logic [VALUE_W-1:0]      m1_2_reg, m2_2_reg;
    logic [DEN_W-1:0]        den2_reg;
    side_t                   side2_reg;
    // Stage 3 registers
    logic [2:0][SPLIT_W+VALUE_W-1:0] pa_lo_reg, pb_lo_reg;
    logic [2:0][HI_W+VALUE_W-1:0]    pa_hi_reg, pb_hi_reg;
    logic [DEN_W-1:0]        den3_reg;
    side_t                   side3_reg;
    // Stage 4 registers
    num_vec_t                na_reg, nb_reg;
    logic [DEN_W-1:0]        den4_reg;
    side_t                   side4_reg;

    logic [2:0][MAG_W-1:0]   mag1_next;
    side_t                   side1_next;
    logic [2:0][MAG_W:0]     diff;
    logic [VALUE_W-1:0]      v1_in [3];
    logic [VALUE_W-1:0]      v2_in [3];

    // Velocity difference, its sign and magnitude, and the zero-total-mass flag
    always_comb
    begin
        v1_in[0] = req.first_vel_x;
        v1_in[1] = req.first_vel_y;
        v1_in[2] = req.first_vel_z;
        v2_in[0] = req.second_vel_x;
        v2_in[1] = req.second_vel_y;
        v2_in[2] = req.second_vel_z;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {{2{v1_in[i][VALUE_W-1]}}, v1_in[i]} -
                      {{2{v2_in[i][VALUE_W-1]}}, v2_in[i]};
            side1_next.v1[i]  = v1_in[i];
            side1_next.v2[i]  = v2_in[i];
            side1_next.neg[i] = diff[i][MAG_W];
            mag1_next[i]      = diff[i][MAG_W] ? MAG_W'(-diff[i]) : diff[i][MAG_W-1:0];
        end
        side1_next.err = ({1'b0, req.first_mass} + {1'b0, req.second_mass}) == '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Advance payload through the four stages
    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag1_next;
        m1_1_reg  <= req.first_mass;
        m2_1_reg  <= req.second_mass;
        den1_reg  <= {1'b0, req.first_mass} + {1'b0, req.second_mass};
        gain1_reg <= gain;
        side1_reg <= side1_next;

        for (int i = 0; i < 3; i++)
        begin
            a2_reg[i] <= PROD_W'(mag1_reg[i]) * PROD_W'(gain1_reg);
        end
        m1_2_reg  <= m1_1_reg;
        m2_2_reg  <= m2_1_reg;
        den2_reg  <= den1_reg;
        side2_reg <= side1_reg;

        for (int i = 0; i < 3; i++)
        begin
            pa_lo_reg[i] <= (SPLIT_W+VALUE_W)'(a2_reg[i][SPLIT_W-1:0]) *
                            (SPLIT_W+VALUE_W)'(m2_2_reg);
            pa_hi_reg[i] <= (HI_W+VALUE_W)'(a2_reg[i][PROD_W-1:SPLIT_W]) *
                            (HI_W+VALUE_W)'(m2_2_reg);
            pb_lo_reg[i] <= (SPLIT_W+VALUE_W)'(a2_reg[i][SPLIT_W-1:0]) *
                            (SPLIT_W+VALUE_W)'(m1_2_reg);
            pb_hi_reg[i] <= (HI_W+VALUE_W)'(a2_reg[i][PROD_W-1:SPLIT_W]) *
                            (HI_W+VALUE_W)'(m1_2_reg);
        end
        den3_reg  <= den2_reg;
        side3_reg <= side2_reg;

        for (int i = 0; i < 3; i++)
        begin
            na_reg[i] <= (NUM_W'(pa_hi_reg[i]) << SPLIT_W) + NUM_W'(pa_lo_reg[i]);
            nb_reg[i] <= (NUM_W'(pb_hi_reg[i]) << SPLIT_W) + NUM_W'(pb_lo_reg[i]);
        end
        den4_reg  <= den3_reg;
        side4_reg <= side3_reg;
    end

    assign out_valid = vld_reg[3];
    assign num_a     = na_reg;
    assign num_b     = nb_reg;
    assign den       = den4_reg;
    assign side      = side4_reg;

endmodule

FILE: rtl/rcr_div.sv
`timescale 1ns / 1ps

module rcr_div
    import rcr_pkg::*;
#(
    parameter int NW = 83,
    parameter int QW = 51,
    parameter int DW = 33
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_valid,
    output logic [QW-1:0] quot
);

    logic [QW-1:0] vld_reg;
    logic [NW-1:0] num_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    // One restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic          vld_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign num_in = num;
            assign den_in = den;
            assign rem_in = DW'(num[NW-1:QW]);
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign trial = {rem_in, num_in[QW-1-k]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[k] <= num_in;
            den_reg[k] <= den_in;
            rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg[k]   <= q_in | (QW'(ge) << (QW-1-k));
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = q_reg[QW-1];

endmodule

FILE: rtl/rcr_delay.sv
`timescale 1ns / 1ps

module rcr_delay
    import rcr_pkg::*;
#(
    parameter int WIDTH = 200,
    parameter int DEPTH = 51
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift side data in step with the divider stages
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: rtl/rcr_back.sv
`timescale 1ns / 1ps

module rcr_back
    import rcr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  quot_vec_t q_a,
    input  quot_vec_t q_b,
    input  side_t     side,
    output logic      done,
    output rsp_t      result
);

    logic             done_reg;
    rsp_t             result_reg;
    rsp_t             result_next;
    logic [VALUE_W-1:0] r1 [3];
    logic [VALUE_W-1:0] r2 [3];
    logic [5:0]       clip;

    // Apply the scaled impulse, clamp, or pass through on zero mass
    always_comb
    begin
        logic signed [RES_W-1:0] v1e;
        logic signed [RES_W-1:0] v2e;
        logic signed [RES_W-1:0] qa;
        logic signed [RES_W-1:0] qb;
        logic [VALUE_W:0]        c1;
        logic [VALUE_W:0]        c2;
        for (int i = 0; i < 3; i++)
        begin
            v1e = RES_W'(signed'(side.v1[i]));
            v2e = RES_W'(signed'(side.v2[i]));
            qa  = RES_W'(q_a[i][PROD_W-1:QSH]);
            qb  = RES_W'(q_b[i][PROD_W-1:QSH]);
            c1  = clamp_val(side.neg[i] ? v1e + qa : v1e - qa);
            c2  = clamp_val(side.neg[i] ? v2e - qb : v2e + qb);
            if (side.err)
            begin
                r1[i]       = side.v1[i];
                r2[i]       = side.v2[i];
                clip[i]     = 1'b0;
                clip[i + 3] = 1'b0;
            end
            else
            begin
                r1[i]       = c1[VALUE_W-1:0];
                r2[i]       = c2[VALUE_W-1:0];
                clip[i]     = c1[VALUE_W];
                clip[i + 3] = c2[VALUE_W];
            end
        end
        result_next.new_first_vel_x  = r1[0];
        result_next.new_first_vel_y  = r1[1];
        result_next.new_first_vel_z  = r1[2];
        result_next.new_second_vel_x = r2[0];
        result_next.new_second_vel_y = r2[1];
        result_next.new_second_vel_z = r2[2];
        result_next.zero_mass_error  = side.err;
        result_next.saturated        = |clip;
    end

    // Hold the strobe for one cycle per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/restitution_collision_response_core.sv
`timescale 1ns / 1ps
// Start to done passes 4 front stages, 51 divider steps and 1 output register.
// Throughput: one transaction per cycle; each divider stage resolves one quotient bit.
// busy stays low; the receiver cannot stall, so done is a single-cycle strobe.
// Reset (async, active low) clears valid bits and sets restitution to 1.0;
// the pipeline payload is not reset.
module restitution_collision_response_core
    import rcr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  req_t           request,
    output logic           done,
    output rsp_t           result,
    input  logic           cfg_we,
    input  logic [E_W-1:0] cfg_wdata
);

    localparam int SIDE_W = $bits(side_t);

    logic [E_W-1:0]    restitution_reg;
    logic [E_W-1:0]    e_sel;
    logic [GAIN_W-1:0] gain;
    logic              f_valid;
    num_vec_t          num_a, num_b;
    logic [DEN_W-1:0]  den;
    side_t             f_side;
    side_t             d_side;
    quot_vec_t         q_a, q_b;
    logic [5:0]        d_valid;

    // Hold the restitution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= RESTITUTION_ONE;
        end
        else if (cfg_we)
        begin
            restitution_reg <= cfg_wdata;
        end
    end

    // Limit e to one and form 1 + e
    assign e_sel = (restitution_reg > RESTITUTION_ONE) ? RESTITUTION_ONE : restitution_reg;
    assign gain  = GAIN_W'(RESTITUTION_ONE) + GAIN_W'(e_sel);
    assign busy  = 1'b0;

    rcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .req       (request),
        .gain      (gain),
        .out_valid (f_valid),
        .num_a     (num_a),
        .num_b     (num_b),
        .den       (den),
        .side      (f_side)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        rcr_div #(.NW(NUM_W), .QW(PROD_W), .DW(DEN_W)) u_div_a (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (f_valid),
            .num       (num_a[i]),
            .den       (den),
            .out_valid (d_valid[i]),
            .quot      (q_a[i])
        );
        rcr_div #(.NW(NUM_W), .QW(PROD_W), .DW(DEN_W)) u_div_b (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (f_valid),
            .num       (num_b[i]),
            .den       (den),
            .out_valid (d_valid[i + 3]),
            .quot      (q_b[i])
        );
    end

    rcr_delay #(.WIDTH(SIDE_W), .DEPTH(PROD_W)) u_delay (
        .clk  (clk),
        .din  (f_side),
        .dout (d_side)
    );

    rcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (&d_valid),
        .q_a      (q_a),
        .q_b      (q_b),
        .side     (d_side),
        .done     (done),
        .result   (result)
    );

endmodule

FILE: sim/restitution_collision_response_core_tb.sv
`timescale 1ns / 1ps

module restitution_collision_response_core_tb;
    import rcr_pkg::*;

    localparam int PIPE_LATENCY = 56;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;

    localparam logic [E_W-1:0] E_ZERO = '0;
    localparam logic [E_W-1:0] E_HALF = E_W'(32768);
    localparam logic [E_W-1:0] E_MAX  = '1;

    localparam logic [VALUE_W-1:0] VEL_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VEL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] MASS_ONE = VALUE_W'(65536);
    localparam logic [VALUE_W-1:0] MASS_MAX = '1;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t rsp;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    req_t           request;
    logic           done;
    rsp_t           result;
    logic           cfg_we;
    logic [E_W-1:0] cfg_wdata;

    logic [E_W-1:0] restitution_cur;
    rsp_t           pending_velocities[$];
    stim_row_t      collision_table[$];
    int             idle_pct;
    int             mismatches;
    int             collisions_sent;
    int             responses_seen;
    int             cycle_count;

    restitution_collision_response_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always #2 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Clip to the signed velocity range, flag any clip
    function automatic logic [VALUE_W-1:0] clip_velocity(input longint v, inout bit sat);
        longint hi;
        longint lo;
        hi = longint'(VEL_MAX);
        lo = -hi - 1;
        if (v > hi)
        begin
            sat = 1'b1;
            return VALUE_W'(hi);
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return VALUE_W'(lo);
        end
        return VALUE_W'(v);
    endfunction

    // Post-collision velocities, exact arithmetic, one truncation per result
    function automatic rsp_t predict_collision(input req_t r, input logic [E_W-1:0] e_reg);
        rsp_t             p;
        logic [VALUE_W:0] total;
        longint unsigned  gain;
        longint           v1[3];
        longint           v2[3];
        longint           d;
        longint unsigned  prod;
        logic [127:0]     num;
        longint           q1;
        longint           q2;
        bit               sat;
        logic [VALUE_W-1:0] n1[3];
        logic [VALUE_W-1:0] n2[3];
        v1[0] = longint'(r.first_vel_x);
        v1[1] = longint'(r.first_vel_y);
        v1[2] = longint'(r.first_vel_z);
        v2[0] = longint'(r.second_vel_x);
        v2[1] = longint'(r.second_vel_y);
        v2[2] = longint'(r.second_vel_z);
        total = {1'b0, r.first_mass} + {1'b0, r.second_mass};
        gain = 65536 + ((e_reg > RESTITUTION_ONE) ? 65536 : longint'(e_reg));
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (total == 0)
            begin
                n1[i] = VALUE_W'(v1[i]);
                n2[i] = VALUE_W'(v2[i]);
            end
            else
            begin
                d = v1[i] - v2[i];
                prod = ((d < 0) ? -d : d) * gain;
                num = 128'(prod) * 128'(r.second_mass);
                q2 = longint'((num / 128'(total)) >> 16);
                num = 128'(prod) * 128'(r.first_mass);
                q1 = longint'((num / 128'(total)) >> 16);
                if (d < 0)
                begin
                    n1[i] = clip_velocity(v1[i] + q2, sat);
                    n2[i] = clip_velocity(v2[i] - q1, sat);
                end
                else
                begin
                    n1[i] = clip_velocity(v1[i] - q2, sat);
                    n2[i] = clip_velocity(v2[i] + q1, sat);
                end
            end
        end
        p.new_first_vel_x  = n1[0];
        p.new_first_vel_y  = n1[1];
        p.new_first_vel_z  = n1[2];
        p.new_second_vel_x = n2[0];
        p.new_second_vel_y = n2[1];
        p.new_second_vel_z = n2[2];
        p.zero_mass_error  = (total == 0);
        p.saturated        = sat;
        return p;
    endfunction

    // Log accepted transactions and check results against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            pending_velocities.push_back(predict_collision(request, restitution_cur));
        end
        if (rst_n && done)
        begin
            responses_seen++;
            if (pending_velocities.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", result);
            end
            else if (result !== pending_velocities[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h got %h", pending_velocities[0], result);
                void'(pending_velocities.pop_front());
            end
            else
            begin
                void'(pending_velocities.pop_front());
            end
        end
    end

    function automatic logic [VALUE_W-1:0] rand_velocity();
        case ($urandom_range(5))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return '0;
            3: return VALUE_W'(int'($urandom_range(2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand_mass();
        case ($urandom_range(6))
            0: return '0;
            1: return MASS_MAX;
            2: return VALUE_W'($urandom_range(1048576));
            3: return VALUE_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_collision(input logic [VALUE_W-1:0] v1,
                                            input logic [VALUE_W-1:0] v2,
                                            input logic [VALUE_W-1:0] m1,
                                            input logic [VALUE_W-1:0] m2);
        req_t r;
        r.first_vel_x  = v1;
        r.first_vel_y  = ~v1;
        r.first_vel_z  = v2;
        r.second_vel_x = v2;
        r.second_vel_y = v1;
        r.second_vel_z = ~v2;
        r.first_mass   = m1;
        r.second_mass  = m2;
        return r;
    endfunction

    // Send one transaction, idling at random first
    task automatic send_collision(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start   = 1'b1;
        request = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        collisions_sent++;
        @(negedge clk);
    endtask

    // Drain the pipeline before touching the register
    task automatic wait_drained();
        start = 1'b0;
        while (pending_velocities.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_restitution(input logic [E_W-1:0] e);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = e;
        @(negedge clk);
        cfg_we = 1'b0;
        restitution_cur = e;
    endtask

    task automatic run_table();
        stim_row_t row;
        rsp_t      pred;
        for (int i = 0; i < collision_table.size(); i++)
        begin
            row  = collision_table[i];
            pred = predict_collision(row.req, restitution_cur);
            // Cross-check hand-written rows against the predictor
            if (row.known && pred !== row.rsp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Table row %0d: expected %h predicted %h", i, row.rsp, pred);
            end
            send_collision(row.req);
        end
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // Hold off once mid-phase until everything has drained
            if (i == count / 2)
                wait_drained();
            send_collision(make_collision(rand_velocity(), rand_velocity(),
                                          rand_mass(), rand_mass()));
        end
    endtask

    function automatic stim_row_t passthrough_row(input logic [VALUE_W-1:0] v1,
                                                  input logic [VALUE_W-1:0] v2);
        stim_row_t row;
        row.req   = make_collision(v1, v2, '0, '0);
        row.known = 1'b1;
        row.rsp.new_first_vel_x  = row.req.first_vel_x;
        row.rsp.new_first_vel_y  = row.req.first_vel_y;
        row.rsp.new_first_vel_z  = row.req.first_vel_z;
        row.rsp.new_second_vel_x = row.req.second_vel_x;
        row.rsp.new_second_vel_y = row.req.second_vel_y;
        row.rsp.new_second_vel_z = row.req.second_vel_z;
        row.rsp.zero_mass_error  = 1'b1;
        row.rsp.saturated        = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t predicted_row(input logic [VALUE_W-1:0] v1,
                                                input logic [VALUE_W-1:0] v2,
                                                input logic [VALUE_W-1:0] m1,
                                                input logic [VALUE_W-1:0] m2);
        stim_row_t row;
        row.req   = make_collision(v1, v2, m1, m2);
        row.known = 1'b0;
        row.rsp   = '0;
        return row;
    endfunction

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        restitution_cur = RESTITUTION_ONE;
        idle_pct        = 14;
        mismatches      = 0;
        collisions_sent = 0;
        responses_seen  = 0;
        cycle_count     = 0;

        // Directed rows: zero total mass, extremes, saturation, one-sided mass
        collision_table.push_back(passthrough_row(VEL_MAX, VEL_MIN));
        collision_table.push_back(passthrough_row('0, 32'h1234_5678));
        collision_table.push_back(predicted_row(VEL_MAX, VEL_MIN, MASS_ONE, MASS_ONE));
        collision_table.push_back(predicted_row(VEL_MIN, VEL_MAX, MASS_ONE, MASS_ONE));
        collision_table.push_back(predicted_row(VEL_MAX, VEL_MIN, MASS_MAX, MASS_MAX));
        collision_table.push_back(predicted_row(VEL_MAX, VEL_MIN, MASS_MAX, 32'd1));
        collision_table.push_back(predicted_row(VEL_MIN, VEL_MAX, 32'd1, MASS_MAX));
        collision_table.push_back(predicted_row(VEL_MAX, '0, '0, MASS_ONE));
        collision_table.push_back(predicted_row(VEL_MIN, '0, MASS_ONE, '0));
        collision_table.push_back(predicted_row('0, '0, MASS_MAX, MASS_MAX));
        collision_table.push_back(predicted_row(32'h0001_0000, 32'hFFFF_0000, MASS_ONE,
                                                32'h0003_0000));
        collision_table.push_back(predicted_row(32'h0000_0001, 32'hFFFF_FFFF, 32'd1, 32'd2));
        collision_table.push_back(predicted_row(32'h7FFF_0000, 32'h8001_0000, 32'd3,
                                                MASS_MAX));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value, then fully inelastic
        run_table();
        write_restitution(E_ZERO);
        run_table();

        // Random phases under different idling and restitution settings
        write_restitution(E_MAX);
        idle_pct = 14;
        run_random(RANDOM_ITEMS);
        write_restitution(E_W'($urandom_range(65536)));
        idle_pct = 62;
        run_random(RANDOM_ITEMS);
        write_restitution(E_HALF);
        idle_pct = 0;
        run_random(RANDOM_ITEMS);

        wait_drained();

        $display("Sent %0d collisions, checked %0d responses", collisions_sent,
                 responses_seen);
        $display("Restitution swept over reset, zero, half, random and above-one values");
        if (mismatches == 0 && pending_velocities.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
